/* src/lbvs_pkg.sv */
// shared types, constants and helper functions of the vertex skinning core
`default_nettype none
package lbvs_pkg;

   localparam int POS_W      = 32;
   localparam int NRM_W      = 16;
   localparam int WGT_W      = 16;
   localparam int BIDX_W     = 8;
   localparam int TOT_W      = 18;
   localparam int T_W        = 52;
   localparam int D_W        = 36;
   localparam int PS_W       = 52;
   localparam int NS_W       = 56;
   localparam int MAG_W      = 56;
   localparam int MUL_A_W    = 36;
   localparam int MUL_B_W    = 33;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int DIV_W      = 56;
   localparam int DEN_W      = 32;
   localparam int SQ_IN_W    = 62;
   localparam int SQ_R_W     = 63;
   localparam int ROOT_W     = 31;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam int BCNT_W     = 7;

   localparam logic [0:0]            OP_PAL_WRITE   = 1'b0;
   localparam logic [0:0]            OP_SKIN        = 1'b1;
   localparam logic [CSR_IDX_W-1:0]  REG_BONE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0]  REG_NORMALS_EN = 1'b1;
   localparam logic [BCNT_W-1:0]     BONE_COUNT_RST = 7'd64;

   typedef struct packed {
      logic [0:0]               op;
      logic [9:0]               palette_addr;
      logic signed [POS_W-1:0]  palette_value;
      logic signed [POS_W-1:0]  bind_x;
      logic signed [POS_W-1:0]  bind_y;
      logic signed [POS_W-1:0]  bind_z;
      logic signed [NRM_W-1:0]  bind_nx;
      logic signed [NRM_W-1:0]  bind_ny;
      logic signed [NRM_W-1:0]  bind_nz;
      logic [31:0]              bone_indices;
      logic [63:0]              bone_weights;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  out_x;
      logic signed [POS_W-1:0]  out_y;
      logic signed [POS_W-1:0]  out_z;
      logic signed [NRM_W-1:0]  out_nx;
      logic signed [NRM_W-1:0]  out_ny;
      logic signed [NRM_W-1:0]  out_nz;
      logic                     rigid;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  num;
      logic [DEN_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                start;
      logic [SQ_IN_W-1:0]  value;
   } sqrt_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LANE,
      ST_RD,
      ST_MP,
      ST_MN,
      ST_AN,
      ST_TR,
      ST_WP,
      ST_WN,
      ST_WD,
      ST_DIVP,
      ST_DIVPW,
      ST_NORM,
      ST_SQM,
      ST_SQA,
      ST_SQRT,
      ST_SQRTW,
      ST_DIVN,
      ST_DIVNW,
      ST_DONE
   } state_type;

   // lanes above the fourth carry no weight
   function automatic logic [WGT_W-1:0] lane_weight(input logic [63:0] wts,
                                                    input logic [3:0] i);
      logic [WGT_W-1:0] w;
      w = '0;
      if (i < 4'd4) w = wts[16*i +: 16];
      return w;
   endfunction

   function automatic logic [BIDX_W-1:0] lane_bone(input logic [31:0] idx,
                                                   input logic [3:0] i);
      logic [BIDX_W-1:0] b;
      b = '0;
      if (i < 4'd4) b = idx[8*i +: 8];
      return b;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (x < -64'sh0000_0000_8000_0000) r = -32'sh8000_0000;
      else r = 32'(x);
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/linear_blend_vertex_skinning_core.sv */
// top level: palette memory, sequencer and datapath of the vertex skinning core
// palette write: stored at the transfer. rigid vertex: bind data passes via the done state to the output.
// skinned vertex: active influences are blended in turn (one multiplier, one palette read port),
//   then three serial position divides; with normals on and a nonzero normal sum, normalize shifts,
//   squares and root, and three serial normal divides.
// one item at a time; req_stall stays high until the result is in the output register.
// synchronous reset restores bone_count 64 and normals on; palette contents are kept.
`default_nettype none
module linear_blend_vertex_skinning_core #(
   parameter int INFLUENCES = 4,
   parameter int BONES      = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire lbvs_pkg::req_type                  req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      lbvs_pkg::rsp_type                  rsp_data,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [lbvs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lbvs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lbvs_pkg::*;

   localparam int PAL_DEPTH = BONES * 12;
   localparam int AW        = $clog2(PAL_DEPTH);
   localparam int LANE_W    = $clog2(INFLUENCES + 1);

   state_type state_ff, state_in;

   logic [BCNT_W-1:0]        bone_count_ff;
   logic                     normals_en_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic [31:0]              pal_mem_ff [PAL_DEPTH];
   logic signed [POS_W-1:0]  rd_data_ff;

   logic signed [POS_W-1:0]  p_ff [3];
   logic signed [NRM_W-1:0]  n_ff [3];
   logic [31:0]              indices_ff;
   logic [63:0]              weights_ff;
   logic [TOT_W-1:0]         total_ff;
   logic [LANE_W-1:0]        lane_ff;
   logic [1:0]               row_ff;
   logic [1:0]               col_ff;
   logic signed [T_W-1:0]    t_ff;
   logic signed [D_W-1:0]    d_ff;
   logic signed [PS_W-1:0]   ps_ff [3];
   logic signed [NS_W-1:0]   ns_ff [3];
   logic [MAG_W-1:0]         mag_ff [3];
   logic [SQ_IN_W-1:0]       len2_ff;
   logic [ROOT_W-1:0]        len_ff;
   logic signed [POS_W-1:0]  pos_ff [3];
   logic signed [NRM_W-1:0]  nrm_ff [3];
   logic                     rigid_ff;

   logic                     req_acc;
   logic [TOT_W-1:0]         req_total;
   logic [WGT_W-1:0]         cur_w;
   logic [BIDX_W-1:0]        cur_bone;
   logic                     lane_skip;
   logic                     lanes_done;
   logic                     any_n;
   logic [MAG_W-1:0]         mag_max;
   logic                     pal_wr;
   logic [AW-1:0]            pal_wr_addr;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic                     rsp_load;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   div_req_type              div_req;
   unit_sts_type             div_sts;
   logic [DIV_W-1:0]         div_quo;
   sqrt_req_type             sqrt_req;
   unit_sts_type             sqrt_sts;
   logic [ROOT_W-1:0]        sqrt_root;

   logic [PS_W-1:0]          ps_abs;
   logic signed [63:0]       quo_s;
   logic signed [POS_W-1:0]  pos_val;
   logic signed [NRM_W-1:0]  nrm_val;

   lbvs_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   lbvs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_sts (div_sts),
      .div_quo (div_quo)
   );

   lbvs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .sqrt_req  (sqrt_req),
      .sqrt_sts  (sqrt_sts),
      .sqrt_root (sqrt_root)
   );

   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      req_total = '0;
      for (int k = 0; k < INFLUENCES; k++) begin
         req_total = req_total + TOT_W'(lane_weight(req_data.bone_weights, 4'(k)));
      end
   end

   always_comb begin
      cur_w      = lane_weight(weights_ff, 4'(lane_ff));
      cur_bone   = lane_bone(indices_ff, 4'(lane_ff));
      lane_skip  = (cur_w == '0) || ({1'b0, cur_bone} >= {2'b0, bone_count_ff})
                   || ({1'b0, cur_bone} >= 9'(BONES));
      lanes_done = lane_ff == LANE_W'(INFLUENCES);
      any_n      = (ns_ff[0] != '0) || (ns_ff[1] != '0) || (ns_ff[2] != '0);
      mag_max    = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
      if (mag_ff[2] > mag_max) mag_max = mag_ff[2];
      pal_wr      = req_acc && (req_data.op == OP_PAL_WRITE)
                    && ({22'b0, req_data.palette_addr} < 32'(PAL_DEPTH));
      pal_wr_addr = AW'({22'b0, req_data.palette_addr});
      rd_addr     = AW'((32'(cur_bone) << 3) + (32'(cur_bone) << 2)
                        + (32'(row_ff) << 2) + 32'(col_ff));
      ps_abs  = ps_ff[col_ff][PS_W-1] ? PS_W'(-ps_ff[col_ff]) : PS_W'(ps_ff[col_ff]);
      quo_s   = signed'(64'(div_quo));
      pos_val = sat32(ps_ff[col_ff][PS_W-1] ? -quo_s : quo_s);
      nrm_val = ns_ff[col_ff][NS_W-1] ? signed'(NRM_W'(0) - div_quo[NRM_W-1:0])
                                      : signed'(div_quo[NRM_W-1:0]);
      rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_data.op == OP_SKIN)) begin
               state_in = (req_total == '0) ? ST_DONE : ST_LANE;
            end
         end
         ST_LANE: begin
            if (lanes_done) state_in = ST_DIVP;
            else if (!lane_skip) state_in = ST_RD;
         end
         ST_RD:    state_in = (col_ff == 2'd3) ? ST_TR : ST_MP;
         ST_MP:    state_in = ST_MN;
         ST_MN:    state_in = ST_AN;
         ST_AN:    state_in = ST_RD;
         ST_TR:    state_in = ST_WP;
         ST_WP:    state_in = ST_WN;
         ST_WN:    state_in = ST_WD;
         ST_WD:    state_in = (row_ff == 2'd2) ? ST_LANE : ST_RD;
         ST_DIVP:  state_in = ST_DIVPW;
         ST_DIVPW: begin
            if (div_sts.done) begin
               if (col_ff != 2'd2) state_in = ST_DIVP;
               else if (normals_en_ff && any_n) state_in = ST_NORM;
               else state_in = ST_DONE;
            end
         end
         ST_NORM: begin
            if ((mag_max[MAG_W-1:30] == '0) && (mag_max[29] == 1'b1)) state_in = ST_SQM;
         end
         ST_SQM:   state_in = ST_SQA;
         ST_SQA:   state_in = (col_ff == 2'd2) ? ST_SQRT : ST_SQM;
         ST_SQRT:  state_in = ST_SQRTW;
         ST_SQRTW: if (sqrt_sts.done) state_in = ST_DIVN;
         ST_DIVN:  state_in = ST_DIVNW;
         ST_DIVNW: begin
            if (div_sts.done) state_in = (col_ff == 2'd2) ? ST_DONE : ST_DIVN;
         end
         ST_DONE:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall      = 1'b1;
      rd_en          = 1'b0;
      mul_a          = '0;
      mul_b          = '0;
      div_req.start  = 1'b0;
      div_req.num    = '0;
      div_req.den    = '0;
      sqrt_req.start = 1'b0;
      sqrt_req.value = len2_ff;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_RD:   rd_en = 1'b1;
         ST_MP: begin
            mul_a = MUL_A_W'(rd_data_ff);
            mul_b = MUL_B_W'(p_ff[col_ff]);
         end
         ST_MN: begin
            mul_a = MUL_A_W'(rd_data_ff);
            mul_b = MUL_B_W'(n_ff[col_ff]);
         end
         ST_WP: begin
            mul_a = MUL_A_W'(sat32(64'(t_ff)));
            mul_b = signed'(MUL_B_W'(cur_w));
         end
         ST_WN: begin
            mul_a = d_ff;
            mul_b = signed'(MUL_B_W'(cur_w));
         end
         ST_DIVP: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_W'(ps_abs) + DIV_W'(total_ff >> 1);
            div_req.den   = DEN_W'(total_ff);
         end
         ST_SQM: begin
            mul_a = signed'(MUL_A_W'(mag_ff[col_ff][29:0]));
            mul_b = signed'(MUL_B_W'(mag_ff[col_ff][29:0]));
         end
         ST_SQRT: sqrt_req.start = 1'b1;
         ST_DIVN: begin
            div_req.start = 1'b1;
            div_req.num   = (DIV_W'(mag_ff[col_ff][29:0]) << 14) + DIV_W'(len_ff >> 1);
            div_req.den   = DEN_W'(len_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bone_count_ff <= BONE_COUNT_RST;
         normals_en_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BONE_COUNT: bone_count_ff <= csr_wdata;
            REG_NORMALS_EN: normals_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pal_wr) pal_mem_ff[pal_wr_addr] <= req_data.palette_value;
      if (rd_en) rd_data_ff <= pal_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.out_x  <= pos_ff[0];
         rsp_data_ff.out_y  <= pos_ff[1];
         rsp_data_ff.out_z  <= pos_ff[2];
         rsp_data_ff.out_nx <= nrm_ff[0];
         rsp_data_ff.out_ny <= nrm_ff[1];
         rsp_data_ff.out_nz <= nrm_ff[2];
         rsp_data_ff.rigid  <= rigid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && (req_data.op == OP_SKIN)) begin
                  lane_ff <= '0;
                  row_ff  <= '0;
                  col_ff  <= '0;
               end
            end
            ST_LANE: if (!lanes_done && lane_skip) lane_ff <= lane_ff + 1'b1;
            ST_AN:   col_ff <= col_ff + 1'b1;
            ST_WD: begin
               col_ff <= '0;
               if (row_ff == 2'd2) begin
                  row_ff  <= '0;
                  lane_ff <= lane_ff + 1'b1;
               end else begin
                  row_ff <= row_ff + 1'b1;
               end
            end
            ST_DIVPW, ST_DIVNW: begin
               if (div_sts.done) col_ff <= (col_ff == 2'd2) ? 2'd0 : col_ff + 1'b1;
            end
            ST_SQA:  col_ff <= (col_ff == 2'd2) ? 2'd0 : col_ff + 1'b1;
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_data.op == OP_SKIN)) begin
               p_ff[0]    <= req_data.bind_x;
               p_ff[1]    <= req_data.bind_y;
               p_ff[2]    <= req_data.bind_z;
               n_ff[0]    <= req_data.bind_nx;
               n_ff[1]    <= req_data.bind_ny;
               n_ff[2]    <= req_data.bind_nz;
               indices_ff <= req_data.bone_indices;
               weights_ff <= req_data.bone_weights;
               total_ff   <= req_total;
               t_ff       <= '0;
               d_ff       <= '0;
               for (int k = 0; k < 3; k++) begin
                  ps_ff[k] <= '0;
                  ns_ff[k] <= '0;
               end
               // zero total weight passes the bind data straight through
               rigid_ff  <= (req_total == '0);
               pos_ff[0] <= req_data.bind_x;
               pos_ff[1] <= req_data.bind_y;
               pos_ff[2] <= req_data.bind_z;
               nrm_ff[0] <= req_data.bind_nx;
               nrm_ff[1] <= req_data.bind_ny;
               nrm_ff[2] <= req_data.bind_nz;
            end
         end
         ST_MN:  t_ff <= t_ff + T_W'(mul_p >>> 16);
         ST_AN:  d_ff <= d_ff + D_W'(mul_p >>> 14);
         ST_TR:  t_ff <= t_ff + T_W'(rd_data_ff);
         ST_WN:  ps_ff[row_ff] <= ps_ff[row_ff] + PS_W'(mul_p);
         ST_WD: begin
            ns_ff[row_ff] <= ns_ff[row_ff] + NS_W'(mul_p);
            t_ff          <= '0;
            d_ff          <= '0;
         end
         ST_DIVPW: begin
            if (div_sts.done) begin
               pos_ff[col_ff] <= pos_val;
               if (col_ff == 2'd2) begin
                  for (int k = 0; k < 3; k++) begin
                     mag_ff[k] <= ns_ff[k][NS_W-1] ? MAG_W'(-ns_ff[k]) : MAG_W'(ns_ff[k]);
                  end
               end
            end
         end
         ST_NORM: begin
            // bring the largest magnitude into [2^29, 2^30)
            if (mag_max[MAG_W-1:30] != '0) begin
               for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] >> 1;
            end else if (mag_max[29] == 1'b0) begin
               for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] << 1;
            end else begin
               len2_ff <= '0;
            end
         end
         ST_SQA:   len2_ff <= len2_ff + SQ_IN_W'(mul_p);
         ST_SQRTW: if (sqrt_sts.done) len_ff <= sqrt_root;
         ST_DIVNW: if (div_sts.done) nrm_ff[col_ff] <= nrm_val;
         default: ;
      endcase
   end

   // a vertex transfer always blocks the next one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.op == OP_SKIN)) |=> req_stall)
      else $error("vertex transfer did not stall the input");

   // the shared divider is never restarted while it is still iterating
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_sts.busy)
      else $error("divider restarted while busy");

   assert property (@(posedge clock) disable iff (reset)
      sqrt_req.start |-> !sqrt_sts.busy)
      else $error("square root restarted while busy");

   // a new result only comes out of the final sequencer state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result appeared outside the done state");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LANE) |-> (lane_ff <= LANE_W'(INFLUENCES)))
      else $error("influence counter ran past the last lane");

endmodule
`default_nettype wire

/* src/lbvs_mul.sv */
// shared signed multiplier with a registered product
`default_nettype none
module lbvs_mul (
   input  wire logic                                  clock,
   input  wire logic signed [lbvs_pkg::MUL_A_W-1:0]   mul_a,
   input  wire logic signed [lbvs_pkg::MUL_B_W-1:0]   mul_b,
   output      logic signed [lbvs_pkg::MUL_P_W-1:0]   mul_p
);
   import lbvs_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule
`default_nettype wire

/* src/lbvs_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none
module lbvs_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lbvs_pkg::div_req_type         div_req,
   output      lbvs_pkg::unit_sts_type        div_sts,
   output      logic [lbvs_pkg::DIV_W-1:0]    div_quo
);
   import lbvs_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W:0]    shifted;
   logic              ge;
   logic [DEN_W-1:0]  rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      rem_in  = ge ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.num;
         den_ff <= div_req.den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
      end
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign div_quo      = quo_ff;

endmodule
`default_nettype wire

/* src/lbvs_sqrt.sv */
// floor integer square root, two radicand bits per cycle
`default_nettype none
module lbvs_sqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lbvs_pkg::sqrt_req_type        sqrt_req,
   output      lbvs_pkg::unit_sts_type        sqrt_sts,
   output      logic [lbvs_pkg::ROOT_W-1:0]   sqrt_root
);
   import lbvs_pkg::*;

   localparam int STEPS = SQ_R_W / 2 + 1;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [SQ_IN_W-1:0]  v_ff;
   logic [SQ_R_W-1:0]   r_ff;
   logic [SQ_R_W-1:0]   bit_ff;
   logic [SQ_R_W-1:0]   trial;
   logic                fits;

   always_comb begin
      trial = r_ff + bit_ff;
      fits  = SQ_R_W'(v_ff) >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (sqrt_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sqrt_req.start) begin
         v_ff   <= sqrt_req.value;
         r_ff   <= '0;
         bit_ff <= SQ_R_W'(1) << (SQ_R_W - 1);
      end else if (busy_ff) begin
         if (fits) begin
            v_ff <= SQ_IN_W'(SQ_R_W'(v_ff) - trial);
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign sqrt_sts.busy = busy_ff;
   assign sqrt_sts.done = done_ff;
   assign sqrt_root     = r_ff[ROOT_W-1:0];

endmodule
`default_nettype wire

/* verif/lbvs_checker.sv */
// channel monitor, skinning predictor and result comparison for the skinning core
`timescale 1ns / 100ps
module lbvs_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire lbvs_pkg::req_type                req_data,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire lbvs_pkg::rsp_type                rsp_data,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [lbvs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [lbvs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output      int                               fail_count,
   output      int                               pending
);
   import lbvs_pkg::*;

   localparam int NBONES = 64;
   localparam int PAL_WORDS = NBONES * 12;

   logic [31:0] pal_mirror [PAL_WORDS];
   int          cur_bones;
   logic        cur_normals;
   rsp_type     skinned_q[$];

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint round_div(input longint s, input longint unsigned d);
      longint unsigned m, q;
      m = (s < 0) ? longint'(-s) : longint'(s);
      q = (m + d / 2) / d;
      return (s < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clip32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic rsp_type skin_vertex(input req_type v);
      rsp_type         o;
      longint          pos[3], nrm[3], pacc[3], nacc[3], onrm[3];
      longint          t, d, m, q;
      longint unsigned total, w, bone, mag[3], mx, len2, len;
      logic            nonzero;
      total = 0;
      nonzero = 1'b0;
      pos[0] = $signed(v.bind_x);
      pos[1] = $signed(v.bind_y);
      pos[2] = $signed(v.bind_z);
      nrm[0] = $signed(v.bind_nx);
      nrm[1] = $signed(v.bind_ny);
      nrm[2] = $signed(v.bind_nz);
      for (int c = 0; c < 3; c++) begin
         pacc[c] = 0;
         nacc[c] = 0;
         onrm[c] = nrm[c];
      end
      for (int i = 0; i < 4; i++) total += v.bone_weights[16*i +: 16];
      o.rigid = (total == 0);
      if (total == 0) begin
         for (int c = 0; c < 3; c++) pacc[c] = pos[c];
      end else begin
         for (int i = 0; i < 4; i++) begin
            w = v.bone_weights[16*i +: 16];
            bone = v.bone_indices[8*i +: 8];
            if (w == 0 || bone >= cur_bones || bone >= NBONES) continue;
            for (int r = 0; r < 3; r++) begin
               t = $signed(pal_mirror[bone*12 + r*4 + 3]);
               d = 0;
               for (int c = 0; c < 3; c++) begin
                  m = $signed(pal_mirror[bone*12 + r*4 + c]);
                  t += (m * pos[c]) >>> 16;
                  d += (m * nrm[c]) >>> 14;
               end
               pacc[r] += clip32(t) * longint'(w);
               nacc[r] += d * longint'(w);
            end
         end
         for (int c = 0; c < 3; c++) begin
            pacc[c] = clip32(round_div(pacc[c], total));
            if (nacc[c] != 0) nonzero = 1'b1;
         end
         if (cur_normals && nonzero) begin
            mx = 0;
            for (int c = 0; c < 3; c++) begin
               mag[c] = (nacc[c] < 0) ? longint'(-nacc[c]) : longint'(nacc[c]);
               if (mag[c] > mx) mx = mag[c];
            end
            // bring the largest component into [2^29, 2^30)
            while (mx >= (64'd1 << 30)) begin
               for (int c = 0; c < 3; c++) mag[c] = mag[c] >> 1;
               mx = mx >> 1;
            end
            while (mx < (64'd1 << 29)) begin
               for (int c = 0; c < 3; c++) mag[c] = mag[c] << 1;
               mx = mx << 1;
            end
            len2 = 0;
            for (int c = 0; c < 3; c++) len2 += mag[c] * mag[c];
            len = int_sqrt(len2);
            for (int c = 0; c < 3; c++) begin
               q = longint'((mag[c] * 16384 + len / 2) / len);
               onrm[c] = (nacc[c] < 0) ? -q : q;
            end
         end
      end
      o.out_x = pacc[0][31:0];
      o.out_y = pacc[1][31:0];
      o.out_z = pacc[2][31:0];
      o.out_nx = onrm[0][15:0];
      o.out_ny = onrm[1][15:0];
      o.out_nz = onrm[2][15:0];
      return o;
   endfunction

   task automatic check_field(input string name, input longint exp, input longint act);
      if (exp != act) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp, act);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      cur_bones = 64;
      cur_normals = 1'b1;
   end

   always @(posedge clock) begin
      rsp_type exp;
      if (reset) begin
         cur_bones = 64;
         cur_normals = 1'b1;
         skinned_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_BONE_COUNT) cur_bones = csr_wdata;
            else if (csr_index == REG_NORMALS_EN) cur_normals = csr_wdata[0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (skinned_q.size() == 0) begin
               $display("%0t unexpected result transfer", $time);
               fail_count++;
            end else begin
               exp = skinned_q.pop_front();
               check_field("out_x", $signed(exp.out_x), $signed(rsp_data.out_x));
               check_field("out_y", $signed(exp.out_y), $signed(rsp_data.out_y));
               check_field("out_z", $signed(exp.out_z), $signed(rsp_data.out_z));
               check_field("out_nx", $signed(exp.out_nx), $signed(rsp_data.out_nx));
               check_field("out_ny", $signed(exp.out_ny), $signed(rsp_data.out_ny));
               check_field("out_nz", $signed(exp.out_nz), $signed(rsp_data.out_nz));
               check_field("rigid", exp.rigid, rsp_data.rigid);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_data.op == OP_PAL_WRITE) begin
               if (req_data.palette_addr < PAL_WORDS)
                  pal_mirror[req_data.palette_addr] = req_data.palette_value;
            end else begin
               skinned_q.push_back(skin_vertex(req_data));
            end
         end
      end
      pending <= skinned_q.size();
   end
endmodule

/* verif/testbench.sv */
// stimulus, clock, reset and verdict for the vertex skinning core
`timescale 1ns / 100ps
module testbench;
   import lbvs_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending;

   logic       word_set [768];
   int         tb_bones;
   int         burst_left;
   bit         hold_go;
   int         stall_mode;

   linear_blend_vertex_skinning_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   lbvs_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always #4 clock = ~clock;

   initial begin
      #60ms;
      $display("testbench failed");
      $finish;
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int cyc;
      cyc = 0;
      stall_mode = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_go) begin
            hold_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (1500) @(posedge clock);
         end else begin
            if (cyc % 400 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= (cyc % 7 < 3);
               default: rsp_stall <= ($urandom_range(0, 99) < 80);
            endcase
         end
      end
   end

   task automatic send(input req_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // the pending count is a registered copy of the checker's queue size
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_BONE_COUNT) tb_bones = val;
   endtask

   task automatic pal_write(input int addr, input logic [31:0] val);
      req_type it;
      it = '0;
      it.op = OP_PAL_WRITE;
      it.palette_addr = 10'(addr);
      it.palette_value = val;
      it.bind_x = $urandom();
      it.bone_weights = {$urandom(), $urandom()};
      send(it);
      if (addr < 768) word_set[addr] = 1'b1;
   endtask

   function automatic bit bone_ready(input int b);
      if (b >= 64) return 1'b0;
      for (int k = 0; k < 12; k++) if (!word_set[b*12 + k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
      endcase
   endfunction

   function automatic logic [15:0] rand_norm();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // legal vertex: any lane that reads the palette names a fully written bone
   function automatic req_type rand_vertex();
      req_type v;
      int      b, hi;
      logic [15:0] w;
      v.op = OP_SKIN;
      v.palette_addr = 10'($urandom_range(0, 1023));
      v.palette_value = $urandom();
      v.bind_x = rand_word();
      v.bind_y = rand_word();
      v.bind_z = rand_word();
      v.bind_nx = rand_norm();
      v.bind_ny = rand_norm();
      v.bind_nz = rand_norm();
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 9))
            0, 1: w = 16'h0;
            2: w = 16'hFFFF;
            default: w = 16'($urandom_range(1, 16'hFFFF));
         endcase
         if ($urandom_range(0, 19) == 0) w = 16'h0;
         b = $urandom_range(0, 255);
         if ($urandom_range(0, 9) < 7 || (w != 0 && b < tb_bones && !bone_ready(b))) begin
            hi = (tb_bones < 8) ? tb_bones - 1 : 7;
            b = $urandom_range(0, hi);
            if ($urandom_range(0, 4) == 0 && tb_bones == 64) b = 63;
         end
         v.bone_weights[16*i +: 16] = w;
         v.bone_indices[8*i +: 8] = 8'(b);
      end
      if ($urandom_range(0, 29) == 0) v.bone_weights = '0;
      return v;
   endfunction

   initial begin
      req_type v;
      int      a, phase_items;
      int      bone_setting [6];
      bone_setting = '{64, 1, 64, 0, 37, 2};
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_BONE_COUNT;
      csr_wdata = '0;
      hold_go = 1'b0;
      burst_left = 0;
      tb_bones = 64;
      foreach (word_set[k]) word_set[k] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(REG_BONE_COUNT, 64);
      write_reg(REG_NORMALS_EN, 1);

      // bone 0 identity, bone 1 at full scale for saturation, others random
      for (int k = 0; k < 12; k++)
         pal_write(k, (k == 0 || k == 5 || k == 10) ? 32'h0001_0000 : 32'h0);
      for (int k = 0; k < 12; k++)
         pal_write(12 + k, (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000);
      for (int b = 2; b < 8; b++)
         for (int k = 0; k < 12; k++) pal_write(b*12 + k, rand_word());
      for (int k = 0; k < 12; k++) pal_write(63*12 + k, $urandom());

      // directed vertices
      v = rand_vertex();
      v.bone_weights = '0;
      send(v);
      v.bind_x = 32'h7FFF_FFFF; v.bind_y = 32'h8000_0000; v.bind_z = 32'h0;
      v.bind_nx = 16'h7FFF; v.bind_ny = 16'h8000; v.bind_nz = 16'h0;
      v.bone_indices = 32'h0000_0000;
      v.bone_weights = 64'hFFFF_FFFF_FFFF_FFFF;
      send(v);
      v.bone_indices = 32'h0101_0101;
      send(v);
      v.bone_indices = 32'hFF80_4001;
      v.bone_weights = 64'h0001_FFFF_8000_0000;
      send(v);
      v.bone_indices = 32'hFFFE_8040;
      v.bone_weights = 64'h1234_0001_FFFF_8000;
      send(v);
      v.bind_nx = 16'h0; v.bind_ny = 16'h0; v.bind_nz = 16'h0;
      v.bone_indices = 32'h0;
      v.bone_weights = 64'h0000_0000_0000_4000;
      send(v);
      pal_write(768, 32'hDEAD_BEEF);
      pal_write(1023, 32'h1234_5678);
      v = rand_vertex();
      send(v);

      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 3) write_reg(REG_NORMALS_EN, 0);
         else if (ph == 4) write_reg(REG_NORMALS_EN, 1);
         if (bone_setting[ph] != 0) write_reg(REG_BONE_COUNT, bone_setting[ph]);
         if (ph == 5) write_reg(REG_BONE_COUNT, 63);
         phase_items = 125;
         for (int n = 0; n < phase_items; n++) begin
            if (ph == 1 && n == 20) hold_go = 1'b1;
            if (ph == 2 && n == 50) wait_idle();
            if ($urandom_range(0, 9) < 4) begin
               a = ($urandom_range(0, 9) == 0) ? $urandom_range(768, 1023)
                                               : $urandom_range(0, 767);
               pal_write(a, rand_word());
            end else begin
               send(rand_vertex());
            end
         end
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule

/* sim.f */
src/lbvs_pkg.sv
src/lbvs_mul.sv
src/lbvs_div.sv
src/lbvs_sqrt.sv
src/linear_blend_vertex_skinning_core.sv
verif/lbvs_checker.sv
verif/testbench.sv
